FILE: rtl/isel_pkg.sv
package isel_pkg;

  localparam int ROW_BITS   = 16;
  localparam int MAX_RANGES = 16;
  localparam int ADDR_BITS  = $clog2(MAX_RANGES);
  localparam int CNT_BITS   = $clog2(MAX_RANGES + 2);
  localparam int POS_BITS   = ROW_BITS + 1;
  localparam int ENT_BITS   = 2 * ROW_BITS;

  typedef enum logic [2:0] {
    CMD_SELECT = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_RANGED = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_ALL    = 3'd4,
    CMD_QUERY  = 3'd5,
    CMD_READ   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_SCAN   = 2'd0,
    MODE_UNION  = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

endpackage

FILE: rtl/isel_ram.sv
module isel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/interval_selection_set.sv
// Channel   Direction  Handshake               Fields
// command   in         start && !busy          cmd row range_start use_anchor augment
//                                              row_count range_number
// result    out        done (one cycle)        selected range_found range_low range_high
//                                              ranges_in_use current_row changed overflow
//
// Clear, select all, replacing ranged select and read range go straight to the
// finish step. Select, query and augmenting ranged select walk the range table
// once and toggle twice, one entry per cycle through the registered read port
// of the table RAM, pausing on an entry that yields two ranges (ST_PUSH2).
// rst is synchronous; after it the table is empty and no clearing pass runs.
// done is high for exactly one cycle; the receiver cannot stall the block.
module interval_selection_set
  import isel_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 cmd,
  input  logic [ROW_BITS-1:0]        row,
  input  logic [ROW_BITS-1:0]        range_start,
  input  logic                       use_anchor,
  input  logic                       augment,
  input  logic [ROW_BITS:0]          row_count,
  input  logic [3:0]                 range_number,
  output logic                       done,
  output logic                       selected,
  output logic                       range_found,
  output logic [ROW_BITS-1:0]        range_low,
  output logic [ROW_BITS-1:0]        range_high,
  output logic [4:0]                 ranges_in_use,
  output logic signed [POS_BITS-1:0] current_row,
  output logic                       changed,
  output logic                       overflow
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_PUSH2  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  localparam logic [POS_BITS-1:0] NONE = '1;

  state_t                state;
  cmd_t                  cmd_q;
  mode_t                 mode;
  logic [ROW_BITS-1:0]   row_q, s_q;
  logic                  aug_q;
  logic [ROW_BITS:0]     count_q;
  logic [3:0]            rnum_q;
  logic [CNT_BITS-1:0]   idx, wr_cnt, total;
  logic                  hit, single0, placed, bank;
  logic [ROW_BITS-1:0]   acc_lo, acc_hi, p2_lo, p2_hi;
  logic [POS_BITS-1:0]   cur, anchor;

  logic [ENT_BITS-1:0]   q0, q1, q;
  logic [ROW_BITS-1:0]   ent_lo, ent_hi;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  last;

  // Walk step results.
  logic                  push_v, need2, hit_n, placed_n;
  logic [ROW_BITS-1:0]   push_lo, push_hi, n2_lo, n2_hi, acc_lo_n, acc_hi_n;

  // Scratch (inactive bank) and active-bank write ports.
  logic                  scr_we, act_we;
  logic [ADDR_BITS-1:0]  scr_addr;
  logic [ENT_BITS-1:0]   scr_data, act_data;

  // Finish step results.
  logic                  restart, fin_sel, fin_found, fin_chg, fin_ovf, commit_ok;
  logic [CNT_BITS-1:0]   fin_total, final_cnt;
  logic [POS_BITS-1:0]   fin_cur, fin_anchor;
  logic                  fin_flip;
  logic [ROW_BITS:0]     limit, clamp;

  // Ranged-select start row, taken from the inputs at acceptance.
  logic [ROW_BITS-1:0]   s_in;

  assign busy   = (state != ST_IDLE);
  assign q      = bank ? q1 : q0;
  assign ent_lo = q[ENT_BITS-1:ROW_BITS];
  assign ent_hi = q[ROW_BITS-1:0];
  assign last   = ((idx + CNT_BITS'(1)) == total);

  always_comb begin
    if (!use_anchor) begin
      s_in = range_start;
    end else if (anchor != NONE) begin
      s_in = anchor[ROW_BITS-1:0];
    end else if (cur != NONE) begin
      s_in = cur[ROW_BITS-1:0];
    end else begin
      s_in = row;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:   rd_addr = (cmd_t'(cmd) == CMD_READ) ? ADDR_BITS'(range_number) : '0;
      ST_FINISH: rd_addr = '0;
      default:   rd_addr = ADDR_BITS'(idx + CNT_BITS'(1));
    endcase
  end

  // One entry of the table against the queried row, the accumulated range or the removed row.
  always_comb begin
    push_v   = 1'b0;
    push_lo  = ent_lo;
    push_hi  = ent_hi;
    need2    = 1'b0;
    n2_lo    = ent_lo;
    n2_hi    = ent_hi;
    acc_lo_n = acc_lo;
    acc_hi_n = acc_hi;
    placed_n = placed;
    hit_n    = hit;
    unique case (mode)
      MODE_SCAN: begin
        if (row_q >= ent_lo && row_q <= ent_hi) begin
          hit_n = 1'b1;
        end
      end
      MODE_UNION: begin
        if ({1'b0, ent_hi} + 1'b1 < {1'b0, acc_lo}) begin
          push_v = 1'b1;
        end else if ({1'b0, ent_lo} > {1'b0, acc_hi} + 1'b1) begin
          push_v = 1'b1;
          if (!placed) begin
            push_lo  = acc_lo;
            push_hi  = acc_hi;
            need2    = 1'b1;
            placed_n = 1'b1;
          end
        end else begin
          if (ent_lo < acc_lo) begin
            acc_lo_n = ent_lo;
          end
          if (ent_hi > acc_hi) begin
            acc_hi_n = ent_hi;
          end
        end
      end
      MODE_REMOVE: begin
        if (row_q < ent_lo || row_q > ent_hi) begin
          push_v = 1'b1;
        end else if (ent_lo == ent_hi) begin
          push_v = 1'b0;
        end else if (row_q == ent_lo) begin
          push_v  = 1'b1;
          push_lo = ent_lo + 1'b1;
        end else if (row_q == ent_hi) begin
          push_v  = 1'b1;
          push_hi = ent_hi - 1'b1;
        end else begin
          push_v  = 1'b1;
          push_hi = row_q - 1'b1;
          need2   = 1'b1;
          n2_lo   = row_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign final_cnt = wr_cnt + CNT_BITS'(mode == MODE_UNION && !placed);
  assign commit_ok = (final_cnt <= CNT_BITS'(MAX_RANGES));
  assign limit     = (ROW_BITS + 1)'(1) << ROW_BITS;
  assign clamp     = (count_q > limit) ? limit : count_q;
  assign restart   = (cmd_q == CMD_TOGGLE) && (mode == MODE_SCAN);

  always_comb begin
    fin_sel    = 1'b0;
    fin_found  = 1'b0;
    fin_chg    = 1'b0;
    fin_ovf    = 1'b0;
    fin_flip   = 1'b0;
    fin_total  = total;
    fin_cur    = cur;
    fin_anchor = anchor;
    act_we     = 1'b0;
    act_data   = {row_q, row_q};
    unique case (cmd_q)
      CMD_SELECT: begin
        fin_anchor = NONE;
        fin_cur    = {1'b0, row_q};
        if (!hit || total > CNT_BITS'(1) || !single0) begin
          act_we    = 1'b1;
          fin_total = CNT_BITS'(1);
          fin_chg   = 1'b1;
        end
      end
      CMD_TOGGLE: begin
        if (commit_ok) begin
          fin_flip   = 1'b1;
          fin_total  = final_cnt;
          fin_anchor = NONE;
          fin_cur    = {1'b0, row_q};
          fin_chg    = 1'b1;
        end else begin
          fin_ovf = 1'b1;
        end
      end
      CMD_RANGED: begin
        if (aug_q && !commit_ok) begin
          fin_ovf = 1'b1;
        end else begin
          if (aug_q) begin
            fin_flip  = 1'b1;
            fin_total = final_cnt;
          end else begin
            act_we    = 1'b1;
            act_data  = {acc_lo, acc_hi};
            fin_total = CNT_BITS'(1);
          end
          fin_anchor = {1'b0, s_q};
          fin_cur    = {1'b0, row_q};
          fin_chg    = 1'b1;
        end
      end
      CMD_CLEAR: begin
        fin_total  = '0;
        fin_anchor = NONE;
        fin_chg    = 1'b1;
      end
      CMD_ALL: begin
        fin_anchor = NONE;
        fin_total  = '0;
        act_data   = {{ROW_BITS{1'b0}}, ROW_BITS'(clamp - 1'b1)};
        if (clamp != '0) begin
          act_we    = 1'b1;
          fin_total = CNT_BITS'(1);
          fin_chg   = 1'b1;
        end
      end
      CMD_QUERY: begin
        fin_sel = hit;
      end
      CMD_READ: begin
        fin_found = (CNT_BITS'(rnum_q) < total);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    scr_we   = 1'b0;
    scr_data = {push_lo, push_hi};
    if (state == ST_EVAL) begin
      scr_we = push_v;
    end else if (state == ST_PUSH2) begin
      scr_we   = 1'b1;
      scr_data = {p2_lo, p2_hi};
    end else if (state == ST_FINISH && !restart) begin
      scr_we   = (mode == MODE_UNION) && !placed;
      scr_data = {acc_lo, acc_hi};
    end
    if (wr_cnt >= CNT_BITS'(MAX_RANGES)) begin
      scr_we = 1'b0;
    end
    scr_addr = wr_cnt[ADDR_BITS-1:0];
  end

  isel_ram #(.WIDTH(ENT_BITS), .DEPTH(MAX_RANGES)) u_ram0 (
    .clk   (clk),
    .we    (bank ? scr_we : act_we),
    .waddr (bank ? scr_addr : '0),
    .wdata (bank ? scr_data : act_data),
    .raddr (rd_addr),
    .rdata (q0)
  );

  isel_ram #(.WIDTH(ENT_BITS), .DEPTH(MAX_RANGES)) u_ram1 (
    .clk   (clk),
    .we    (bank ? act_we : scr_we),
    .waddr (bank ? '0 : scr_addr),
    .wdata (bank ? act_data : scr_data),
    .raddr (rd_addr),
    .rdata (q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      total  <= '0;
      cur    <= NONE;
      anchor <= NONE;
      bank   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_t'(cmd);
            row_q   <= row;
            aug_q   <= augment;
            count_q <= row_count;
            rnum_q  <= range_number;
            s_q     <= s_in;
            acc_lo  <= (s_in < row) ? s_in : row;
            acc_hi  <= (s_in < row) ? row : s_in;
            idx     <= '0;
            wr_cnt  <= '0;
            hit     <= 1'b0;
            placed  <= 1'b0;
            mode    <= MODE_SCAN;
            state   <= ST_FINISH;
            unique case (cmd_t'(cmd))
              CMD_SELECT, CMD_TOGGLE, CMD_QUERY: begin
                if (total != '0) begin
                  state <= ST_EVAL;
                end
              end
              CMD_RANGED: begin
                if (augment) begin
                  mode <= MODE_UNION;
                  if (total != '0) begin
                    state <= ST_EVAL;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EVAL: begin
          if (idx == '0) begin
            single0 <= (ent_lo == ent_hi);
          end
          hit    <= hit_n;
          placed <= placed_n;
          acc_lo <= acc_lo_n;
          acc_hi <= acc_hi_n;
          p2_lo  <= n2_lo;
          p2_hi  <= n2_hi;
          if (push_v) begin
            wr_cnt <= wr_cnt + 1'b1;
          end
          if (need2) begin
            state <= ST_PUSH2;
          end else if (last) begin
            state <= ST_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_PUSH2: begin
          wr_cnt <= wr_cnt + 1'b1;
          if (last) begin
            state <= ST_FINISH;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_EVAL;
          end
        end
        ST_FINISH: begin
          if (restart) begin
            // Membership is known; now build the new table into the other bank.
            mode   <= hit ? MODE_REMOVE : MODE_UNION;
            acc_lo <= row_q;
            acc_hi <= row_q;
            placed <= 1'b0;
            wr_cnt <= '0;
            idx    <= '0;
            state  <= (total == '0) ? ST_FINISH : ST_EVAL;
          end else begin
            total         <= fin_total;
            cur           <= fin_cur;
            anchor        <= fin_anchor;
            bank          <= bank ^ fin_flip;
            done          <= 1'b1;
            selected      <= fin_sel;
            range_found   <= fin_found;
            range_low     <= fin_found ? ent_lo : '0;
            range_high    <= fin_found ? ent_hi : '0;
            ranges_in_use <= 5'(fin_total);
            current_row   <= fin_cur;
            changed       <= fin_chg;
            overflow      <= fin_ovf;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/tb_interval_selection_set.sv
`timescale 1ns / 1ps

module tb_interval_selection_set;
  import isel_pkg::*;

  typedef struct {
    cmd_t                op;
    logic [ROW_BITS-1:0] row;
    logic [ROW_BITS-1:0] rstart;
    logic                anchor_sel;
    logic                add;
    logic [ROW_BITS:0]   count;
    logic [3:0]          rnum;
    int                  gap;
    bit                  drain;
  } command_t;

  typedef struct {
    logic                       selected;
    logic                       range_found;
    logic [ROW_BITS-1:0]        range_low;
    logic [ROW_BITS-1:0]        range_high;
    logic [4:0]                 ranges_in_use;
    logic signed [POS_BITS-1:0] current_row;
    logic                       changed;
    logic                       overflow;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] cmd = CMD_NONE;
  logic [ROW_BITS-1:0] row = '0;
  logic [ROW_BITS-1:0] range_start = '0;
  logic use_anchor = 1'b0;
  logic augment = 1'b0;
  logic [ROW_BITS:0] row_count = '0;
  logic [3:0] range_number = '0;
  logic done;
  logic selected, range_found, changed, overflow;
  logic [ROW_BITS-1:0] range_low, range_high;
  logic [4:0] ranges_in_use;
  logic signed [POS_BITS-1:0] current_row;

  interval_selection_set DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Model of the range table.
  int unsigned span_lo[MAX_RANGES];
  int unsigned span_hi[MAX_RANGES];
  int unsigned span_count = 0;
  int cursor = -1;
  int pivot = -1;
  int unsigned work_lo[$];
  int unsigned work_hi[$];

  command_t pending_cmds[$];
  status_t  expected_status[$];
  int errors = 0;
  int accepted = 0;
  int issued = 0;
  int hold_off = 0;
  int overflows = 0;
  int changes = 0;

  function automatic bit row_held(int unsigned r);
    for (int i = 0; i < span_count; i++)
      if (r >= span_lo[i] && r <= span_hi[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void merge_span(int unsigned lo, int unsigned hi);
    bit placed = 1'b0;
    work_lo.delete();
    work_hi.delete();
    for (int i = 0; i < span_count; i++) begin
      if (span_hi[i] + 1 < lo) begin
        work_lo.push_back(span_lo[i]); work_hi.push_back(span_hi[i]);
      end else if (span_lo[i] > hi + 1) begin
        if (!placed) begin
          work_lo.push_back(lo); work_hi.push_back(hi); placed = 1'b1;
        end
        work_lo.push_back(span_lo[i]); work_hi.push_back(span_hi[i]);
      end else begin
        if (span_lo[i] < lo) lo = span_lo[i];
        if (span_hi[i] > hi) hi = span_hi[i];
      end
    end
    if (!placed) begin
      work_lo.push_back(lo); work_hi.push_back(hi);
    end
  endfunction

  function automatic void carve_row(int unsigned r);
    work_lo.delete();
    work_hi.delete();
    for (int i = 0; i < span_count; i++) begin
      if (r < span_lo[i] || r > span_hi[i]) begin
        work_lo.push_back(span_lo[i]); work_hi.push_back(span_hi[i]);
      end else if (span_lo[i] == span_hi[i]) begin
      end else if (r == span_lo[i]) begin
        work_lo.push_back(r + 1); work_hi.push_back(span_hi[i]);
      end else if (r == span_hi[i]) begin
        work_lo.push_back(span_lo[i]); work_hi.push_back(r - 1);
      end else begin
        work_lo.push_back(span_lo[i]); work_hi.push_back(r - 1);
        work_lo.push_back(r + 1); work_hi.push_back(span_hi[i]);
      end
    end
  endfunction

  function automatic bit store_work();
    if (work_lo.size() > MAX_RANGES) return 1'b0;
    foreach (work_lo[i]) begin
      span_lo[i] = work_lo[i];
      span_hi[i] = work_hi[i];
    end
    span_count = work_lo.size();
    return 1'b1;
  endfunction

  function automatic void single_span(int unsigned lo, int unsigned hi);
    span_lo[0] = lo;
    span_hi[0] = hi;
    span_count = 1;
  endfunction

  function automatic status_t apply_command(command_t c);
    status_t s = '{default: '0};
    int unsigned first, lo, hi, n;
    case (c.op)
      CMD_SELECT: begin
        pivot = -1;
        cursor = c.row;
        if (!row_held(c.row) || span_count > 1 || span_lo[0] != span_hi[0]) begin
          single_span(c.row, c.row);
          s.changed = 1'b1;
        end
      end
      CMD_TOGGLE: begin
        if (row_held(c.row)) carve_row(c.row);
        else merge_span(c.row, c.row);
        if (store_work()) begin
          pivot = -1;
          cursor = c.row;
          s.changed = 1'b1;
        end else s.overflow = 1'b1;
      end
      CMD_RANGED: begin
        if (!c.anchor_sel) first = c.rstart;
        else if (pivot != -1) first = pivot;
        else if (cursor != -1) first = cursor;
        else first = c.row;
        lo = first < c.row ? first : c.row;
        hi = first < c.row ? c.row : first;
        if (c.add) begin
          merge_span(lo, hi);
          if (!store_work()) s.overflow = 1'b1;
        end else single_span(lo, hi);
        if (!s.overflow) begin
          pivot = first;
          cursor = c.row;
          s.changed = 1'b1;
        end
      end
      CMD_CLEAR: begin
        span_count = 0;
        pivot = -1;
        s.changed = 1'b1;
      end
      CMD_ALL: begin
        pivot = -1;
        span_count = 0;
        n = c.count > (1 << ROW_BITS) ? (1 << ROW_BITS) : c.count;
        if (n != 0) begin
          single_span(0, n - 1);
          s.changed = 1'b1;
        end
      end
      CMD_QUERY: s.selected = row_held(c.row);
      CMD_READ: if (c.rnum < span_count) begin
        s.range_found = 1'b1;
        s.range_low = ROW_BITS'(span_lo[c.rnum]);
        s.range_high = ROW_BITS'(span_hi[c.rnum]);
      end
      default: ;
    endcase
    s.ranges_in_use = 5'(span_count);
    s.current_row = POS_BITS'(cursor);
    return s;
  endfunction

  // Driver: inputs move on the falling edge only.
  always @(negedge clk) begin
    command_t c;
    if (!rst && !(start && accepted != issued)) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].gap > 0) begin
        hold_off <= pending_cmds[0].gap - 1;
        pending_cmds[0].gap = 0;
        start <= 1'b0;
      end else if (pending_cmds[0].drain && expected_status.size() != 0) begin
        start <= 1'b0;
      end else begin
        c = pending_cmds.pop_front();
        cmd <= c.op;
        row <= c.row;
        range_start <= c.rstart;
        use_anchor <= c.anchor_sel;
        augment <= c.add;
        row_count <= c.count;
        range_number <= c.rnum;
        start <= 1'b1;
        issued <= issued + 1;
      end
    end
  end

  // Monitor: checks finished transactions, then predicts the one just accepted.
  always @(posedge clk) begin
    status_t e;
    command_t c;
    if (!rst) begin
      if (done) begin
        if (expected_status.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          e = expected_status.pop_front();
          if (selected !== e.selected) begin
            $error("selected: expected %0d, got %0d", e.selected, selected); errors++;
          end
          if (range_found !== e.range_found) begin
            $error("range_found: expected %0d, got %0d", e.range_found, range_found);
            errors++;
          end
          if (range_low !== e.range_low) begin
            $error("range_low: expected %0d, got %0d", e.range_low, range_low); errors++;
          end
          if (range_high !== e.range_high) begin
            $error("range_high: expected %0d, got %0d", e.range_high, range_high);
            errors++;
          end
          if (ranges_in_use !== e.ranges_in_use) begin
            $error("ranges_in_use: expected %0d, got %0d", e.ranges_in_use, ranges_in_use);
            errors++;
          end
          if (current_row !== e.current_row) begin
            $error("current_row: expected %0d, got %0d", e.current_row, current_row);
            errors++;
          end
          if (changed !== e.changed) begin
            $error("changed: expected %0d, got %0d", e.changed, changed); errors++;
          end
          if (overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, overflow); errors++;
          end
        end
      end
      if (start && !busy) begin
        c.op = cmd_t'(cmd);
        c.row = row;
        c.rstart = range_start;
        c.anchor_sel = use_anchor;
        c.add = augment;
        c.count = row_count;
        c.rnum = range_number;
        e = apply_command(c);
        overflows += e.overflow;
        changes += e.changed;
        expected_status.push_back(e);
        accepted <= accepted + 1;
      end
    end
  end

  function automatic command_t make_cmd(cmd_t op, int unsigned r, int unsigned rs = 0,
                                        bit ua = 0, bit ag = 0, int unsigned n = 0,
                                        int unsigned k = 0);
    command_t c;
    c.op = op; c.row = ROW_BITS'(r); c.rstart = ROW_BITS'(rs); c.anchor_sel = ua;
    c.add = ag; c.count = (ROW_BITS + 1)'(n); c.rnum = 4'(k); c.gap = 0; c.drain = 1'b0;
    return c;
  endfunction

  function automatic command_t random_cmd(bit narrow);
    command_t c;
    int unsigned pick = $urandom_range(99);
    int unsigned lim = narrow ? 80 : 16'hFFFF;
    c = make_cmd(CMD_NONE, $urandom_range(lim), $urandom_range(lim), $urandom_range(1),
                 $urandom_range(1), $urandom_range(17'h1FFFF), $urandom_range(15));
    if (pick < 35) c.op = CMD_TOGGLE;
    else if (pick < 52) c.op = CMD_RANGED;
    else if (pick < 58) c.op = CMD_SELECT;
    else if (pick < 61) c.op = CMD_CLEAR;
    else if (pick < 64) c.op = CMD_ALL;
    else if (pick < 80) c.op = CMD_QUERY;
    else if (pick < 98) c.op = CMD_READ;
    if (c.op == CMD_ALL && $urandom_range(1)) c.count = (ROW_BITS + 1)'($urandom_range(300));
    if (c.op == CMD_RANGED && narrow) c.rstart = ROW_BITS'(c.row + $urandom_range(3) - 1);
    c.gap = $urandom_range(3) == 0 ? 0 : $urandom_range(15);
    c.drain = ($urandom_range(60) == 0);
    return c;
  endfunction

  initial begin
    command_t c;
    bit narrow;
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RANGED, 40, 0, 1, 1));
    pending_cmds.push_back(make_cmd(CMD_SELECT, 16'hFFFF));
    pending_cmds.push_back(make_cmd(CMD_SELECT, 16'hFFFF));
    pending_cmds.push_back(make_cmd(CMD_TOGGLE, 0));
    pending_cmds.push_back(make_cmd(CMD_TOGGLE, 2));
    pending_cmds.push_back(make_cmd(CMD_TOGGLE, 1));
    pending_cmds.push_back(make_cmd(CMD_SELECT, 1));
    pending_cmds.push_back(make_cmd(CMD_RANGED, 10, 16'hFFFF, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TOGGLE, 500));
    pending_cmds.push_back(make_cmd(CMD_RANGED, 3, 0, 1, 1));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 16'hFFFF));
    pending_cmds.push_back(make_cmd(CMD_QUERY, 2));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 15));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0));
    pending_cmds.push_back(make_cmd(CMD_ALL, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_ALL, 0, 0, 0, 0, 17'h1FFFF));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_ALL, 0, 0, 0, 0, 17'h10000));
    pending_cmds.push_back(make_cmd(CMD_TOGGLE, 300));
    // Punch holes until the table is full, so the last splits of this loop are refused.
    for (int i = 0; i < 16; i++) pending_cmds.push_back(make_cmd(CMD_TOGGLE, 4 * i + 1));
    pending_cmds.push_back(make_cmd(CMD_RANGED, 16'hFFF0, 16'hFFF0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_NONE, 16'hFFFF, 16'hFFFF, 1, 1, 17'h1FFFF, 15));
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    for (int b = 0; b < 26; b++) begin
      narrow = ($urandom_range(3) != 0);
      for (int i = 0; i < 50; i++) begin
        c = random_cmd(narrow);
        if (b == 5 && i == 0) c.drain = 1'b1;
        pending_cmds.push_back(c);
      end
      c = make_cmd($urandom_range(1) ? CMD_CLEAR : CMD_SELECT, $urandom_range(80));
      pending_cmds.push_back(c);
    end
    wait (pending_cmds.size() == 0 && accepted == issued);
    wait (expected_status.size() == 0);
    repeat (50) @(posedge clk);
    $display("Ran %0d transactions: %0d changed the selection, %0d were refused as full.",
             accepted, changes, overflows);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d transactions still outstanding.", expected_status.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/isel_pkg.sv
rtl/isel_ram.sv
rtl/interval_selection_set.sv
test/tb_interval_selection_set.sv
